// ----- hdl/hslp_pkg.sv -----
// ----------------------------------------------------------------------------
// hslp_pkg
// Shared types and constants for the HTTP status line parser: item layouts,
// character classes handed from the front end to the back end, verdict codes.
// ----------------------------------------------------------------------------
package hslp_pkg;

  // Input item: one byte of the response buffer
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } hslp_in_t;

  // Result item: verdict and status code so far
  typedef struct packed {
    logic [1:0] verdict;
    logic [9:0] status_code;
  } hslp_out_t;

  // Verdict codes
  localparam logic [1:0] VERDICT_PENDING = 2'd0;
  localparam logic [1:0] VERDICT_DONE    = 2'd1;
  localparam logic [1:0] VERDICT_ERROR   = 2'd2;

  // Characters the parser looks for
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Character classes
  typedef enum logic [3:0] {
    CLS_H,
    CLS_T,
    CLS_P,
    CLS_SLASH,
    CLS_DOT,
    CLS_SPACE,
    CLS_CR,
    CLS_LF,
    CLS_DIGIT,
    CLS_OTHER
  } char_class_e;

  // Classified byte passed between front and back
  typedef struct packed {
    char_class_e cls;
    logic        nonzero;  // digit 1..9
    logic [3:0]  digit;
    logic        last;
  } hslp_token_t;

  // Queue depths (powers of two, at least 2)
  localparam int TOKEN_QUEUE_DEPTH  = 2;
  localparam int RESULT_QUEUE_DEPTH = 2;

endpackage

// ----- hdl/hslp_fifo.sv -----
// ----------------------------------------------------------------------------
// hslp_fifo
// Small register queue with push/full and pop/empty. Depth must be a power of two; the block does not enforce it.
// ----------------------------------------------------------------------------
module hslp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_wr, do_rd;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_rd) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (do_wr && !do_rd) count_q <= count_q + CntW'(1);
      else if (do_rd && !do_wr) count_q <= count_q - CntW'(1);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

// ----- hdl/hslp_front.sv -----
// ----------------------------------------------------------------------------
// hslp_front
// Accepts input bytes and classifies each into a token for the parser.
// ----------------------------------------------------------------------------
module hslp_front (
  input  hslp_pkg::hslp_in_t    item_i,
  input  logic                  push_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output hslp_pkg::hslp_token_t token_o
);
  import hslp_pkg::*;

  logic is_digit;

  assign is_digit = (item_i.byte_in >= CH_ZERO) && (item_i.byte_in <= CH_NINE);
  assign q_push_o = push_i && !q_full_i;

  // Byte classification
  always_comb begin
    token_o.nonzero = is_digit && (item_i.byte_in != CH_ZERO);
    token_o.digit   = item_i.byte_in[3:0];
    token_o.last    = item_i.last_byte;
    if (is_digit) begin
      token_o.cls = CLS_DIGIT;
    end else begin
      case (item_i.byte_in)
        CH_H:     token_o.cls = CLS_H;
        CH_T:     token_o.cls = CLS_T;
        CH_P:     token_o.cls = CLS_P;
        CH_SLASH: token_o.cls = CLS_SLASH;
        CH_DOT:   token_o.cls = CLS_DOT;
        CH_SPACE: token_o.cls = CLS_SPACE;
        CH_CR:    token_o.cls = CLS_CR;
        CH_LF:    token_o.cls = CLS_LF;
        default:  token_o.cls = CLS_OTHER;
      endcase
    end
  end

endmodule

// ----- hdl/hslp_back.sv -----
// ----------------------------------------------------------------------------
// hslp_back
// Status line state machine: takes one token per cycle when one is queued and
// results have room; keeps phase, code and held verdict; one result per token.
// ----------------------------------------------------------------------------
module hslp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hslp_pkg::hslp_token_t token_i,
  input  logic                  tok_empty_i,
  output logic                  tok_pop_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output hslp_pkg::hslp_out_t   result_o
);
  import hslp_pkg::*;

  typedef enum logic [3:0] {
    PH_START,
    PH_H,
    PH_HT,
    PH_HTT,
    PH_HTTP,
    PH_MAJOR_FIRST,
    PH_MAJOR,
    PH_MINOR_FIRST,
    PH_MINOR,
    PH_CODE,
    PH_AFTER_CODE,
    PH_TEXT,
    PH_NEED_LF
  } phase_e;

  phase_e     phase_q, phase_d, phase_adv;
  logic [9:0] acc_q, acc_d, acc_adv, acc_next_digit;
  logic [1:0] cnt_q, cnt_d, cnt_adv;
  logic [1:0] held_q, held_d, verdict_adv, verdict;
  logic       fire;

  assign fire       = !tok_empty_i && !res_full_i;
  assign tok_pop_o  = fire;
  assign res_push_o = fire;

  // acc * 10 + digit, kept to 10 bits
  assign acc_next_digit = {acc_q[6:0], 3'b000} + {acc_q[8:0], 1'b0} + {6'd0, token_i.digit};

  // One parse step
  always_comb begin
    phase_adv   = phase_q;
    acc_adv     = acc_q;
    cnt_adv     = cnt_q;
    verdict_adv = VERDICT_ERROR;
    case (phase_q)
      PH_START: if (token_i.cls == CLS_H) begin
        phase_adv = PH_H;  verdict_adv = VERDICT_PENDING;
      end
      PH_H: if (token_i.cls == CLS_T) begin
        phase_adv = PH_HT;  verdict_adv = VERDICT_PENDING;
      end
      PH_HT: if (token_i.cls == CLS_T) begin
        phase_adv = PH_HTT;  verdict_adv = VERDICT_PENDING;
      end
      PH_HTT: if (token_i.cls == CLS_P) begin
        phase_adv = PH_HTTP;  verdict_adv = VERDICT_PENDING;
      end
      PH_HTTP: if (token_i.cls == CLS_SLASH) begin
        phase_adv = PH_MAJOR_FIRST;  verdict_adv = VERDICT_PENDING;
      end
      PH_MAJOR_FIRST: if (token_i.nonzero) begin
        phase_adv = PH_MAJOR;  verdict_adv = VERDICT_PENDING;
      end
      PH_MAJOR: begin
        if (token_i.cls == CLS_DOT) begin
          phase_adv = PH_MINOR_FIRST;  verdict_adv = VERDICT_PENDING;
        end else if (token_i.cls == CLS_DIGIT) begin
          verdict_adv = VERDICT_PENDING;
        end
      end
      PH_MINOR_FIRST: if (token_i.cls == CLS_DIGIT) begin
        phase_adv = PH_MINOR;  verdict_adv = VERDICT_PENDING;
      end
      PH_MINOR: begin
        if (token_i.cls == CLS_SPACE) begin
          phase_adv = PH_CODE;  verdict_adv = VERDICT_PENDING;
        end else if (token_i.cls == CLS_DIGIT) begin
          verdict_adv = VERDICT_PENDING;
        end
      end
      PH_CODE: begin
        if (token_i.cls == CLS_SPACE) begin
          verdict_adv = VERDICT_PENDING;
        end else if (token_i.cls == CLS_DIGIT) begin
          acc_adv     = acc_next_digit;
          cnt_adv     = cnt_q + 2'd1;
          verdict_adv = VERDICT_PENDING;
          if (cnt_q == 2'd2) phase_adv = PH_AFTER_CODE;
        end
      end
      PH_AFTER_CODE: begin
        if (token_i.cls == CLS_SPACE || token_i.cls == CLS_DOT) begin
          phase_adv = PH_TEXT;  verdict_adv = VERDICT_PENDING;
        end else if (token_i.cls == CLS_CR) begin
          phase_adv = PH_NEED_LF;  verdict_adv = VERDICT_PENDING;
        end else if (token_i.cls == CLS_LF) begin
          verdict_adv = VERDICT_DONE;
        end
      end
      PH_TEXT: begin
        verdict_adv = VERDICT_PENDING;
        if (token_i.cls == CLS_CR) phase_adv = PH_NEED_LF;
        else if (token_i.cls == CLS_LF) verdict_adv = VERDICT_DONE;
      end
      PH_NEED_LF: if (token_i.cls == CLS_LF) verdict_adv = VERDICT_DONE;
      default: verdict_adv = VERDICT_ERROR;
    endcase
  end

  // Held verdict, end of buffer and restart
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    verdict = held_q;
    if (held_q == VERDICT_PENDING) begin
      phase_d = phase_adv;
      acc_d   = acc_adv;
      cnt_d   = cnt_adv;
      verdict = verdict_adv;
      if (token_i.last && verdict_adv == VERDICT_PENDING) verdict = VERDICT_ERROR;
    end
    held_d = verdict;
    result_o.verdict     = verdict;
    result_o.status_code = acc_d;
    if (token_i.last) begin
      phase_d = PH_START;
      acc_d   = '0;
      cnt_d   = '0;
      held_d  = VERDICT_PENDING;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      acc_q   <= '0;
      cnt_q   <= '0;
      held_q  <= VERDICT_PENDING;
    end else if (fire) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      held_q  <= held_d;
    end
  end

endmodule

// ----- hdl/http_status_line_parser.sv -----
// ----------------------------------------------------------------------------
// http_status_line_parser
// Checks an HTTP response status line one byte per item and reports verdict
// and status code for every byte.
// ----------------------------------------------------------------------------
// Every accepted byte gives exactly one result item, in order. The block takes
// one byte per clock and delivers one result per clock when pop is held high.
// A byte's result is registered first in the token queue behind the classifier,
// then, through the parser state machine, in the result queue, where it can be
// popped. Both queues are TOKEN_QUEUE_DEPTH and RESULT_QUEUE_DEPTH entries
// deep, so a stalled consumer backs up into full only after those entries
// fill. A byte with last_byte set ends the buffer; the parser starts a new
// status line with the next byte.
module http_status_line_parser #(
  parameter int TokenDepth  = hslp_pkg::TOKEN_QUEUE_DEPTH,
  parameter int ResultDepth = hslp_pkg::RESULT_QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  hslp_pkg::hslp_in_t  item_i,
  output logic                empty,
  input  logic                pop,
  output hslp_pkg::hslp_out_t result_o
);
  import hslp_pkg::*;

  hslp_token_t tok_w, tok_r;
  hslp_out_t   res_w;
  logic        tok_push, tok_full, tok_pop, tok_empty;
  logic        res_push, res_full;

  assign full = tok_full;

  // Classifier
  hslp_front u_front (
    .item_i   (item_i),
    .push_i   (push),
    .q_full_i (tok_full),
    .q_push_o (tok_push),
    .token_o  (tok_w)
  );

  // Token queue between classifier and parser
  hslp_fifo #(
    .WIDTH ($bits(hslp_token_t)),
    .DEPTH (TokenDepth)
  ) u_tok_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .wdata_i (tok_w),
    .full_o  (tok_full),
    .pop_i   (tok_pop),
    .rdata_o (tok_r),
    .empty_o (tok_empty)
  );

  // Parser
  hslp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .token_i     (tok_r),
    .tok_empty_i (tok_empty),
    .tok_pop_o   (tok_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .result_o    (res_w)
  );

  // Result queue
  hslp_fifo #(
    .WIDTH ($bits(hslp_out_t)),
    .DEPTH (ResultDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_w),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (result_o),
    .empty_o (empty)
  );

endmodule

// ----- hdl/hslp_checker.sv -----
// ----------------------------------------------------------------------------
// hslp_checker
// Port-level checks for the status line parser, bound to the top level.
// ----------------------------------------------------------------------------
module hslp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input hslp_pkg::hslp_out_t result_o
);
  import hslp_pkg::*;

  // Reset leaves both queues drained
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> empty && !full)
    else $error("queues not empty during reset");

  // A waiting result holds until it is taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("result changed while stalled");

  // Only defined verdict codes leave the block
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.verdict == VERDICT_PENDING || result_o.verdict == VERDICT_DONE ||
                result_o.verdict == VERDICT_ERROR))
    else $error("undefined verdict code");

  // Three decimal digits never exceed 999
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> result_o.status_code <= 10'd999)
    else $error("status code out of range");

  // No item taken while the result queue stays empty: still nothing to pop
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && !full) ##1 (empty && !(push && !full)) |=> empty)
    else $error("result without input");

endmodule

bind http_status_line_parser hslp_checker u_hslp_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
